// ----- hw/rtl/bps_pkg.sv -----
// Shared constants, widths and the command type of the Brownian path step unit.
`default_nettype none

package bps_pkg;

    // Fraction bits of times, values and the drift and volatility registers.
    localparam int FRAC_BITS   = 16;
    // Fraction bits of the normal sample.
    localparam int SAMPLE_FRAC = 12;

    // Field widths.
    localparam int TIME_W   = 32;
    localparam int VALUE_W  = 32;
    localparam int SAMPLE_W = 16;
    localparam int DRIFT_W  = 32;
    localparam int VOL_W    = 31;

    // Square root of dt << FRAC_BITS: the radicand is padded to an even width.
    localparam int RAD_W  = TIME_W + FRAC_BITS + ((TIME_W + FRAC_BITS) % 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int CNT_W  = $clog2(ROOT_W);

    // Product and sum widths.
    localparam int DPROD_W = DRIFT_W + TIME_W + 1;
    localparam int VPROD_W = VOL_W + ROOT_W;
    localparam int VS_W    = VPROD_W - FRAC_BITS;
    localparam int VZ_W    = VS_W + 1 + SAMPLE_W;
    localparam int SUM_W   = 66;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic REG_DRIFT = 1'b0;
    localparam logic REG_VOL   = 1'b1;

    // One classified item as handed from the front to the back.
    typedef struct packed {
        logic                       path_start;
        logic                       time_backward;
        logic        [TIME_W-1:0]   dt;
        logic signed [VALUE_W-1:0]  start_value;
        logic signed [SAMPLE_W-1:0] normal_sample;
    } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bps_if.sv -----
// Channel interfaces for input items and result items.
`default_nettype none

interface bps_in_if;
    logic        valid;
    logic        ready;
    logic        path_start;
    logic [31:0] grid_time;
    logic signed [31:0] start_value;
    logic signed [15:0] normal_sample;

    modport source (output valid, output path_start, output grid_time,
                    output start_value, output normal_sample, input ready);
    modport sink (input valid, input path_start, input grid_time,
                  input start_value, input normal_sample, output ready);
endinterface

interface bps_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] path_value;
    logic        value_saturated;
    logic        time_backward;

    modport source (output valid, output path_value, output value_saturated,
                    output time_backward, input ready);
    modport sink (input valid, input path_value, input value_saturated,
                  input time_backward, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/brownian_path_step_unit.sv -----
// Top level of the Brownian path step unit: configuration registers, front, queue and back.
//
// Usage: each transaction on item_in is one grid point of an arithmetic Brownian
// motion path. With path_start high the start_value is returned unchanged and
// becomes the previous point; otherwise the unit returns the previous value plus
// drift_rate*dt + volatility_scale*sqrt(dt)*normal_sample, saturated to 32 bits.
// Each item yields exactly one transaction on result_out, in order.
// Configuration: APB writes to drift_rate (address 0) and volatility_scale
// (address 4); write them only while no item is in flight.
// Sequence: a path start goes from the queue straight to the output load; a step
// takes the command from the queue, then passes the square root unit, which
// resolves one root bit per cycle, the two multiply stages, the sum and the
// output load.
// One item is processed at a time: the back end takes no new item from the queue
// until it has loaded the result of the last one.
// A two-entry command queue lets item_in accept while the back end is busy.
// When result_out stalls, the finished result waits in the output register and
// the back end holds; item_in stalls once the queue is full.
// Reset clears both registers, the previous time and value, and all handshakes.
`default_nettype none

module brownian_path_step_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    bps_in_if.sink           item_in,
    bps_out_if.source        result_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic signed [bps_pkg::DRIFT_W-1:0] drift_reg, drift_next;
    logic [bps_pkg::VOL_W-1:0]          vol_reg, vol_next;
    logic                               cfg_write;
    logic                               q_push, q_full, q_pop, q_not_empty;
    bps_pkg::cmd_t                      push_data, pop_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Register write decode.
    always_comb
    begin
        drift_next = drift_reg;
        vol_next   = vol_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                bps_pkg::REG_DRIFT: drift_next = pwdata;
                bps_pkg::REG_VOL:   vol_next   = pwdata[bps_pkg::VOL_W-1:0];
                default:            drift_next = drift_reg;
            endcase
        end
    end

    // Register read mux.
    always_comb
    begin
        case (paddr[2])
            bps_pkg::REG_DRIFT: prdata = drift_reg;
            bps_pkg::REG_VOL:   prdata = {1'b0, vol_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drift_reg <= '0;
            vol_reg   <= '0;
        end
        else
        begin
            drift_reg <= drift_next;
            vol_reg   <= vol_next;
        end
    end

    bps_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (item_in),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (push_data)
    );

    bps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .not_empty (q_not_empty)
    );

    bps_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .drift_rate       (drift_reg),
        .volatility_scale (vol_reg),
        .q_not_empty      (q_not_empty),
        .q_data           (pop_data),
        .q_pop            (q_pop),
        .result_out       (result_out)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/bps_queue.sv -----
// Short command queue between the front and the back.
`default_nettype none

module bps_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire bps_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output bps_pkg::cmd_t      pop_data,
    output logic               not_empty
);

    bps_pkg::cmd_t                     mem_reg [bps_pkg::QUEUE_DEPTH];
    logic [bps_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [bps_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [bps_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                              do_push, do_pop;

    assign full      = (count_reg == bps_pkg::QCNT_W'(bps_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == bps_pkg::QPTR_W'(bps_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == bps_pkg::QPTR_W'(bps_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bps_front.sv -----
// Front end: accepts items, forms the time step and flags backward time.
`default_nettype none

module bps_front (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bps_in_if.sink        item_in,
    input  wire logic     q_full,
    output logic          q_push,
    output bps_pkg::cmd_t q_data
);

    logic [bps_pkg::TIME_W-1:0] prev_time_reg, prev_time_next;
    logic                       accept;

    assign item_in.ready = !q_full;
    assign accept        = item_in.valid && !q_full;
    assign q_push        = accept;

    // Classify the item and compute dt against the previous grid time.
    always_comb
    begin
        q_data.path_start    = item_in.path_start;
        q_data.start_value   = item_in.start_value;
        q_data.normal_sample = item_in.normal_sample;
        q_data.dt            = '0;
        q_data.time_backward = 1'b0;
        if (!item_in.path_start)
        begin
            if (item_in.grid_time >= prev_time_reg)
            begin
                q_data.dt = item_in.grid_time - prev_time_reg;
            end
            else
            begin
                q_data.time_backward = 1'b1;
            end
        end
    end

    // Every accepted item becomes the previous time point.
    always_comb
    begin
        prev_time_next = prev_time_reg;
        if (accept)
        begin
            prev_time_next = item_in.grid_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
        end
        else
        begin
            prev_time_reg <= prev_time_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bps_back.sv -----
// Back end: square root, drift and volatility terms, accumulation and output register.
`default_nettype none

module bps_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic signed [31:0]          drift_rate,
    input  wire logic [30:0]                 volatility_scale,
    input  wire logic                        q_not_empty,
    input  wire bps_pkg::cmd_t               q_data,
    output logic                             q_pop,
    bps_out_if.source                        result_out
);

    localparam int RadW   = bps_pkg::RAD_W;
    localparam int RootW  = bps_pkg::ROOT_W;
    localparam int RemW   = bps_pkg::REM_W;
    localparam int CntW   = bps_pkg::CNT_W;
    localparam int SumW   = bps_pkg::SUM_W;
    localparam int DprodW = bps_pkg::DPROD_W;
    localparam int VprodW = bps_pkg::VPROD_W;
    localparam int VsW    = bps_pkg::VS_W;
    localparam int VzW    = bps_pkg::VZ_W;
    localparam int ValW   = bps_pkg::VALUE_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROOT  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]                        state_reg, state_next;
    logic [CntW-1:0]                   cnt_reg, cnt_next;
    logic [RadW-1:0]                   rad_reg, rad_next;
    logic [RemW-1:0]                   rem_reg, rem_next;
    logic [RootW-1:0]                  root_reg, root_next;
    bps_pkg::cmd_t                     cmd_reg, cmd_next;
    logic signed [DprodW-1:0]          dprod_reg, dprod_next;
    logic [VprodW-1:0]                 vprod_reg, vprod_next;
    logic signed [VzW-1:0]             vz_reg, vz_next;
    logic signed [ValW-1:0]            res_val_reg, res_val_next;
    logic                              res_sat_reg, res_sat_next;
    logic signed [ValW-1:0]            prev_val_reg, prev_val_next;
    logic                              out_valid_reg, out_valid_next;
    logic signed [ValW-1:0]            out_val_reg, out_val_next;
    logic                              out_sat_reg, out_sat_next;
    logic                              out_back_reg, out_back_next;

    logic [RadW-1:0]                   rad_init;
    logic [RemW-1:0]                   rem_shift, trial;
    logic [VsW-1:0]                    vs;
    logic signed [DprodW-1:0]          dterm;
    logic signed [VzW-1:0]             vterm;
    logic signed [SumW-1:0]            sum;
    logic                              sum_sat;
    logic                              out_free;

    assign rad_init = {{(RadW - bps_pkg::TIME_W){1'b0}}, q_data.dt} << bps_pkg::FRAC_BITS;

    // One root bit per cycle: bring down two radicand bits and try to subtract.
    assign rem_shift = {rem_reg[RemW-3:0], rad_reg[RadW-1 -: 2]};
    assign trial     = {{(RemW - RootW - 2){1'b0}}, root_reg, 2'b01};

    // Scale stage operands and the three-term sum with saturation.
    assign vs      = vprod_reg[VprodW-1:bps_pkg::FRAC_BITS];
    assign dterm   = dprod_reg >>> bps_pkg::FRAC_BITS;
    assign vterm   = vz_reg >>> bps_pkg::SAMPLE_FRAC;
    assign sum     = {{(SumW - ValW){prev_val_reg[ValW-1]}}, prev_val_reg}
                   + {{(SumW - DprodW){dterm[DprodW-1]}}, dterm}
                   + {{(SumW - VzW){vterm[VzW-1]}}, vterm};
    assign sum_sat = !((&sum[SumW-1:ValW-1]) || !(|sum[SumW-1:ValW-1]));

    assign out_free = !out_valid_reg || result_out.ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_not_empty;

    assign result_out.valid           = out_valid_reg;
    assign result_out.path_value      = out_val_reg;
    assign result_out.value_saturated = out_sat_reg;
    assign result_out.time_backward   = out_back_reg;

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        cmd_next       = cmd_reg;
        dprod_next     = dprod_reg;
        vprod_next     = vprod_reg;
        vz_next        = vz_reg;
        res_val_next   = res_val_reg;
        res_sat_next   = res_sat_reg;
        prev_val_next  = prev_val_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        out_val_next   = out_val_reg;
        out_sat_next   = out_sat_reg;
        out_back_next  = out_back_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    cmd_next = q_data;
                    rad_next = rad_init;
                    rem_next = '0;
                    root_next = '0;
                    cnt_next = '0;
                    if (q_data.path_start)
                    begin
                        // A path start passes its initial value through.
                        res_val_next = q_data.start_value;
                        res_sat_next = 1'b0;
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT:
            begin
                rad_next = rad_reg << 2;
                if (rem_shift >= trial)
                begin
                    rem_next  = rem_shift - trial;
                    root_next = {root_reg[RootW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift;
                    root_next = {root_reg[RootW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(RootW - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                dprod_next = drift_rate * $signed({1'b0, cmd_reg.dt});
                vprod_next = volatility_scale * root_reg;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                vz_next    = $signed({1'b0, vs}) * cmd_reg.normal_sample;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                res_sat_next = sum_sat;
                if (sum_sat)
                begin
                    res_val_next = sum[SumW-1] ? {1'b1, {(ValW-1){1'b0}}}
                                               : {1'b0, {(ValW-1){1'b1}}};
                end
                else
                begin
                    res_val_next = sum[ValW-1:0];
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Load the output register once it is free and record the point.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = res_val_reg;
                    out_sat_next   = res_sat_reg;
                    out_back_next  = cmd_reg.time_backward;
                    prev_val_next  = res_val_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            prev_val_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            prev_val_reg  <= prev_val_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        cmd_reg      <= cmd_next;
        dprod_reg    <= dprod_next;
        vprod_reg    <= vprod_next;
        vz_reg       <= vz_next;
        res_val_reg  <= res_val_next;
        res_sat_reg  <= res_sat_next;
        out_val_reg  <= out_val_next;
        out_sat_reg  <= out_sat_next;
        out_back_reg <= out_back_next;
    end

endmodule

`default_nettype wire
